### rtl/bqt_pkg.sv
// shared types, character codes and the tokenizer step function
package bqt_pkg;

    // token kinds
    localparam logic [2:0] K_WORD  = 3'd0;
    localparam logic [2:0] K_OR    = 3'd1;
    localparam logic [2:0] K_AND   = 3'd2;
    localparam logic [2:0] K_NOT   = 3'd3;
    localparam logic [2:0] K_OPEN  = 3'd4;
    localparam logic [2:0] K_CLOSE = 3'd5;
    localparam logic [2:0] K_QUOTE = 3'd6;
    localparam logic [2:0] K_END   = 3'd7;

    // characters the tokenizer looks for
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // keyword match outcomes
    localparam logic [1:0] M_NO   = 2'd0;
    localparam logic [1:0] M_YES  = 2'd1;
    localparam logic [1:0] M_WAIT = 2'd2;

    // results one input can cause, and drain passes needed for a full window
    localparam int MAX_RES = 4;
    localparam int DRAIN_PASSES = 6;

    // record queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] wbyte;
        logic       wend;
    } bqt_res_t;

    // all results caused by one accepted transaction
    typedef struct packed {
        logic [1:0]           last_idx;
        bqt_res_t [MAX_RES-1:0] res;
    } bqt_rec_t;

    typedef struct packed {
        logic [2:0][7:0] win;
        logic [1:0]      cnt;
        logic            in_word;
    } bqt_state_t;

    typedef struct packed {
        bqt_state_t             st;
        logic [2:0]             n;
        bqt_res_t [MAX_RES-1:0] res;
    } bqt_step_t;

    function automatic logic bqt_is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic bqt_ends_word(input logic [7:0] c);
        return c == CH_PIPE || c == CH_BANG || c == CH_LPAR || c == CH_RPAR ||
               c == CH_QUOTE || bqt_is_space(c);
    endfunction

    // shift out k bytes from the window front
    function automatic bqt_state_t bqt_drop(input bqt_state_t s, input logic [1:0] k);
        bqt_state_t r;
        r = s;
        case (k)
            2'd1:
            begin
                r.win = {8'h00, s.win[2], s.win[1]};
            end
            2'd2:
            begin
                r.win = {16'h0000, s.win[2]};
            end
            2'd3:
            begin
                r.win = '0;
            end
            default:
            begin
                r.win = s.win;
            end
        endcase
        r.cnt = s.cnt - k;
        return r;
    endfunction

    // match window bytes 1 (and 2) against a keyword whose first byte matches
    function automatic logic [1:0] bqt_match(input bqt_state_t s, input logic [7:0] k1,
                                             input logic [7:0] k2, input logic three,
                                             input logic ended);
        logic [1:0] m;
        if (s.cnt <= 2'd1)
        begin
            m = ended ? M_NO : M_WAIT;
        end
        else if (s.win[1] != k1)
        begin
            m = M_NO;
        end
        else if (!three)
        begin
            m = M_YES;
        end
        else if (s.cnt <= 2'd2)
        begin
            m = ended ? M_NO : M_WAIT;
        end
        else if (s.win[2] != k2)
        begin
            m = M_NO;
        end
        else
        begin
            m = M_YES;
        end
        return m;
    endfunction

    function automatic void bqt_put(inout bqt_res_t [MAX_RES-1:0] res, inout logic [2:0] n,
                                    input logic [2:0] kind, input logic [7:0] wbyte,
                                    input logic wend);
        if (n < 3'(MAX_RES))
        begin
            res[n[1:0]].kind  = kind;
            res[n[1:0]].wbyte = wbyte;
            res[n[1:0]].wend  = wend;
            n = n + 3'd1;
        end
    endfunction

    // one input byte: append to the window, resolve what can be resolved
    function automatic bqt_step_t bqt_step(input bqt_state_t s_in, input logic [7:0] c,
                                           input logic eoq);
        bqt_step_t  r;
        bqt_state_t s;
        logic       ended;
        logic       stop;
        logic       wend;
        logic [7:0] b;
        logic [7:0] k1;
        logic [7:0] k2;
        logic       three;
        logic [2:0] kind;
        logic [1:0] m;
        logic [2:0] n;
        bqt_res_t [MAX_RES-1:0] res;

        s     = s_in;
        ended = eoq || (c == CH_NUL);
        stop  = 1'b0;
        n     = 3'd0;
        res   = '0;

        // append the byte while not at end
        if (!ended)
        begin
            case (s.cnt)
                2'd0:
                begin
                    s.win[0] = c;
                end
                2'd1:
                begin
                    s.win[1] = c;
                end
                2'd2:
                begin
                    s.win[2] = c;
                end
                default:
                begin
                    s.win = s.win;
                end
            endcase
            if (s.cnt != 2'd3)
            begin
                s.cnt = s.cnt + 2'd1;
            end
        end

        // drain passes over the window
        for (int i = 0; i < DRAIN_PASSES; i++)
        begin
            if (!stop && s.cnt != 2'd0)
            begin
                b = s.win[0];
                if (s.in_word)
                begin
                    if (s.cnt == 2'd1 && !ended)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        wend = (s.cnt == 2'd1) ? 1'b1 : bqt_ends_word(s.win[1]);
                        bqt_put(res, n, K_WORD, b, wend);
                        s = bqt_drop(s, 2'd1);
                        if (wend)
                        begin
                            s.in_word = 1'b0;
                        end
                    end
                end
                else if (bqt_is_space(b))
                begin
                    s = bqt_drop(s, 2'd1);
                end
                else if (b == CH_O || b == CH_N || b == CH_A)
                begin
                    k1    = (b == CH_O) ? CH_R : (b == CH_N) ? CH_O : CH_N;
                    k2    = (b == CH_N) ? CH_T : CH_D;
                    three = (b != CH_O);
                    kind  = (b == CH_O) ? K_OR : (b == CH_N) ? K_NOT : K_AND;
                    m     = bqt_match(s, k1, k2, three, ended);
                    if (m == M_WAIT)
                    begin
                        stop = 1'b1;
                    end
                    else if (m == M_YES)
                    begin
                        bqt_put(res, n, kind, 8'h00, 1'b0);
                        s = bqt_drop(s, three ? 2'd3 : 2'd2);
                    end
                    else
                    begin
                        s.in_word = 1'b1;
                    end
                end
                else if (b == CH_PIPE || b == CH_AMP)
                begin
                    m = bqt_match(s, b, b, 1'b0, ended);
                    if (m == M_WAIT)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        bqt_put(res, n, (b == CH_PIPE) ? K_OR : K_AND, 8'h00, 1'b0);
                        s = bqt_drop(s, (m == M_YES) ? 2'd2 : 2'd1);
                    end
                end
                else if (b == CH_BANG || b == CH_LPAR || b == CH_RPAR || b == CH_QUOTE)
                begin
                    kind = (b == CH_BANG) ? K_NOT : (b == CH_LPAR) ? K_OPEN :
                           (b == CH_RPAR) ? K_CLOSE : K_QUOTE;
                    bqt_put(res, n, kind, 8'h00, 1'b0);
                    s = bqt_drop(s, 2'd1);
                end
                else
                begin
                    s.in_word = 1'b1;
                end
            end
        end

        // end of string: end token and back to the reset state
        if (ended)
        begin
            bqt_put(res, n, K_END, 8'h00, 1'b0);
            s = '0;
        end

        r.st  = s;
        r.n   = n;
        r.res = res;
        return r;
    endfunction

endpackage

### rtl/bqt_front.sv
// front end: lookahead window, classification and result record build
module bqt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_char,
    input  logic              end_of_query,
    output logic              rec_valid,
    output bqt_pkg::bqt_rec_t rec
);
    import bqt_pkg::*;

    bqt_state_t state_reg;
    bqt_state_t state_next;
    bqt_step_t  step;

    // resolve the window for the incoming byte
    always_comb
    begin
        step       = bqt_step(state_reg, in_char, end_of_query);
        state_next = accept ? step.st : state_reg;
        rec_valid  = accept && (step.n != 3'd0);
        rec.res      = step.res;
        rec.last_idx = 2'(step.n - 3'd1);
    end

    // window and word-mode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bqt_queue.sv
// small record queue between the front end and the result serializer
module bqt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  bqt_pkg::bqt_rec_t wr_data,
    input  logic              rd_en,
    output bqt_pkg::bqt_rec_t rd_data,
    output logic              full,
    output logic              empty
);
    import bqt_pkg::*;

    bqt_rec_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign full    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/bqt_back.sv
// back end: walks the results of the head record one per pop
module bqt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bqt_pkg::bqt_rec_t head,
    input  logic              q_empty,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output logic [2:0]        token_kind,
    output logic [7:0]        word_byte,
    output logic              word_end,
    output logic              last
);
    import bqt_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;

    // current result of the head record
    always_comb
    begin
        empty      = q_empty;
        token_kind = head.res[idx_reg].kind;
        word_byte  = head.res[idx_reg].wbyte;
        word_end   = head.res[idx_reg].wend;
        last       = (idx_reg == head.last_idx);
        take       = pop && !q_empty;
        q_rd       = take && last;
        idx_next   = idx_reg;
        if (take)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // position inside the head record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### rtl/boolean_query_tokenizer.sv
// top level of the boolean query tokenizer
// Takes one query byte per transaction (push while full is low) and emits or/and/not,
// paren, quote and word-byte tokens, ending each query with an end token. An input
// transaction is accepted every cycle while the four-record queue between the
// classifier and the output serializer has room; each input yields zero to four
// results, which are registered in the queue and reach the output behind any earlier
// records, one per cycle while pop is held: sustained throughput is one result per
// cycle, set by the output serializer. A byte that needs lookahead (keyword prefixes,
// the current word byte) is held until the following bytes or the end of the query resolve it.
module boolean_query_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       end_of_query,
    input  logic       pop,
    output logic       empty,
    output logic [2:0] token_kind,
    output logic [7:0] word_byte,
    output logic       word_end,
    output logic       last
);
    import bqt_pkg::*;

    logic     accept;
    logic     rec_valid;
    bqt_rec_t rec;
    bqt_rec_t head;
    logic     q_rd;
    logic     q_empty;

    // input transaction accepted
    assign accept = push && !full;

    bqt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_char      (in_char),
        .end_of_query (end_of_query),
        .rec_valid    (rec_valid),
        .rec          (rec)
    );

    bqt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec),
        .rd_en   (q_rd),
        .rd_data (head),
        .full    (full),
        .empty   (q_empty)
    );

    bqt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .token_kind (token_kind),
        .word_byte  (word_byte),
        .word_end   (word_end),
        .last       (last)
    );

endmodule
